FILE: rtl/tbpf_pkg.sv
// Shared types and constants of the tiled background pixel fetch block.
// Depends on nothing; every other file of the block but tbpf_vram refers to it by scoped names.
package tbpf_pkg;

  // Item operation codes.
  localparam logic [1:0] FUNC_VRAM_WR = 2'd0;
  localparam logic [1:0] FUNC_PAL_WR  = 2'd1;
  localparam logic [1:0] FUNC_FETCH   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_CONTROL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_H_SCROLL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V_SCROLL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOSAIC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_ENABLE  = 3'd4;

  // Background palette geometry.
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // Width of the address arithmetic before the wrap at the VRAM size.
  localparam int CALC_W = 18;

  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] mem_addr;
    logic [15:0] write_data;
    logic [7:0]  pixel_x;
    logic [7:0]  line_y;
    logic [1:0]  pass_priority;
  } in_t;

  typedef struct packed {
    logic [14:0] color;
    logic        opaque;
  } out_t;

  typedef struct packed {
    logic [15:0] bg_control;
    logic [8:0]  h_scroll;
    logic [8:0]  v_scroll;
    logic [3:0]  mosaic_height;
    logic        layer_enable;
  } cfg_t;

  // Item after scrolling, ready for the map lookup.
  typedef struct packed {
    logic [1:0]  func;
    logic [14:0] mem_addr;
    logic [15:0] write_data;
    logic        hit;
    logic [8:0]  px;
    logic [8:0]  py;
  } front_t;

  // Item after the tile address is known.
  typedef struct packed {
    logic [1:0]        func;
    logic [PAL_AW-1:0] pal_waddr;
    logic [15:0]       write_data;
    logic              hit;
    logic [3:0]        pal_bank;
    logic              byte_sel;
    logic              nib_sel;
  } tile_t;

endpackage

FILE: rtl/tbpf_front.sv
// Front stages of the pixel fetch: vertical mosaic snap, scrolling and map address.
// Depends on tbpf_pkg.
module tbpf_front #(
  parameter int VRAM_WORDS = 32768
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         in_push_i,
  input  tbpf_pkg::in_t                in_data_i,
  input  tbpf_pkg::cfg_t               cfg_i,
  output logic                         s3_valid_o,
  output tbpf_pkg::front_t             s3_o,
  output logic [$clog2(VRAM_WORDS)-1:0] map_addr_o,
  output logic                         vram_wr_pend_o
);

  localparam int AW = $clog2(VRAM_WORDS);
  localparam logic [tbpf_pkg::CALC_W-1:0] VramN  = tbpf_pkg::CALC_W'(VRAM_WORDS);
  localparam logic [tbpf_pkg::CALC_W-1:0] Vram2N = tbpf_pkg::CALC_W'(2 * VRAM_WORDS);

  logic             s1_valid_q;
  tbpf_pkg::in_t    s1_q;
  logic             s2_valid_q;
  tbpf_pkg::in_t    s2_q;
  logic [3:0]       s2_rem_q;
  logic             s3_valid_q;
  tbpf_pkg::front_t s3_q;
  tbpf_pkg::front_t s3_d;

  logic [4:0]  mos_div;
  logic [3:0]  rem_a;
  logic [4:0]  trial_a;
  logic [3:0]  rem_b;
  logic [4:0]  trial_b;
  logic [7:0]  line_snap;

  logic [5:0]  col;
  logic [5:0]  row;
  logic [1:0]  map_size;
  logic        col_hi;
  logic        row_hi;
  logic [11:0] map_off;
  logic [tbpf_pkg::CALC_W-1:0] map_sum;
  logic [tbpf_pkg::CALC_W-1:0] map_step;
  logic [tbpf_pkg::CALC_W-1:0] map_red;

  assign mos_div = {1'b0, cfg_i.mosaic_height} + 5'd1;

  // Restoring division of the line by the mosaic height plus one, upper four bits.
  always_comb begin
    rem_a   = '0;
    trial_a = '0;
    for (int i = 7; i >= 4; i--) begin
      trial_a = {rem_a, s1_q.line_y[i]};
      if (trial_a >= mos_div) begin
        trial_a = trial_a - mos_div;
      end
      rem_a = trial_a[3:0];
    end
  end

  // Lower four bits; the remainder then snaps the line to the mosaic grid.
  always_comb begin
    rem_b   = s2_rem_q;
    trial_b = '0;
    for (int i = 3; i >= 0; i--) begin
      trial_b = {rem_b, s2_q.line_y[i]};
      if (trial_b >= mos_div) begin
        trial_b = trial_b - mos_div;
      end
      rem_b = trial_b[3:0];
    end
  end

  always_comb begin
    line_snap       = cfg_i.bg_control[6] ? (s2_q.line_y - {4'b0, rem_b}) : s2_q.line_y;
    s3_d.func       = s2_q.func;
    s3_d.mem_addr   = s2_q.mem_addr;
    s3_d.write_data = s2_q.write_data;
    s3_d.hit        = (s2_q.func == tbpf_pkg::FUNC_FETCH) && cfg_i.layer_enable &&
                      (cfg_i.bg_control[1:0] == s2_q.pass_priority);
    s3_d.px         = {1'b0, s2_q.pixel_x} + cfg_i.h_scroll;
    s3_d.py         = {1'b0, line_snap} + cfg_i.v_scroll;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_push_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q     <= in_data_i;
      s2_q     <= s1_q;
      s2_rem_q <= rem_a;
      s3_q     <= s3_d;
    end
  end

  // Map entry address; 64-wide and 64-tall maps add pages of 0x400 halfwords.
  // The sum stays below four times the smallest VRAM size; wrap in two steps.
  always_comb begin
    col      = s3_q.px[8:3];
    row      = s3_q.py[8:3];
    map_size = cfg_i.bg_control[15:14];
    col_hi   = map_size[0] & col[5];
    row_hi   = map_size[1] & row[5];
    map_off  = {row_hi & map_size[0], col_hi | (row_hi & ~map_size[0]), row[4:0], col[4:0]};
    map_sum  = {3'b0, cfg_i.bg_control[12:8], 10'b0} + {6'b0, map_off};
    map_step = (map_sum >= Vram2N) ? (map_sum - Vram2N) : map_sum;
    map_red  = (map_step >= VramN) ? (map_step - VramN) : map_step;
  end

  assign map_addr_o     = map_red[AW-1:0];
  assign s3_valid_o     = s3_valid_q;
  assign s3_o           = s3_q;
  assign vram_wr_pend_o = (s1_valid_q && (s1_q.func == tbpf_pkg::FUNC_VRAM_WR)) ||
                          (s2_valid_q && (s2_q.func == tbpf_pkg::FUNC_VRAM_WR)) ||
                          (s3_valid_q && (s3_q.func == tbpf_pkg::FUNC_VRAM_WR));

endmodule

FILE: rtl/tbpf_tile_addr.sv
// Tile address stages: applies the map entry's flips and forms the pixel data address.
// Depends on tbpf_pkg.
module tbpf_tile_addr #(
  parameter int VRAM_WORDS = 32768
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          s3_valid_i,
  input  tbpf_pkg::front_t              s3_i,
  input  logic [15:0]                   map_entry_i,
  input  tbpf_pkg::cfg_t                cfg_i,
  output logic                          s5_valid_o,
  output tbpf_pkg::tile_t               s5_o,
  output logic [$clog2(VRAM_WORDS)-1:0] vram_addr_o
);

  localparam int AW = $clog2(VRAM_WORDS);
  localparam logic [tbpf_pkg::CALC_W-1:0] VramN  = tbpf_pkg::CALC_W'(VRAM_WORDS);
  localparam logic [tbpf_pkg::CALC_W-1:0] Vram2N = tbpf_pkg::CALC_W'(2 * VRAM_WORDS);

  logic                        s4_valid_q;
  tbpf_pkg::front_t            s4_q;
  logic                        s5_valid_q;
  tbpf_pkg::tile_t             s5_q;
  logic [tbpf_pkg::CALC_W-1:0] s5_addr_q;

  tbpf_pkg::tile_t             s5_d;
  logic [2:0]                  tx;
  logic [2:0]                  ty;
  logic                        bpp8;
  logic [tbpf_pkg::CALC_W-1:0] tile_off;
  logic [tbpf_pkg::CALC_W-1:0] raw_addr;
  logic [tbpf_pkg::CALC_W-1:0] addr_step;
  logic [tbpf_pkg::CALC_W-1:0] addr_red;

  always_comb begin
    bpp8     = cfg_i.bg_control[7];
    tx       = map_entry_i[10] ? ~s4_q.px[2:0] : s4_q.px[2:0];
    ty       = map_entry_i[11] ? ~s4_q.py[2:0] : s4_q.py[2:0];
    // Halfword offset in the tile set: 32 halfwords per 8bpp tile, 16 per 4bpp tile.
    tile_off = bpp8 ? {3'b0, map_entry_i[9:0], ty, tx[2:1]}
                    : {4'b0, map_entry_i[9:0], ty, tx[2]};
    raw_addr = (s4_q.func == tbpf_pkg::FUNC_VRAM_WR) ? {3'b0, s4_q.mem_addr}
               : ({3'b0, cfg_i.bg_control[3:2], 13'b0} + tile_off);
    // The raw address stays below four times the VRAM size; wrap in two steps.
    addr_step = (raw_addr >= Vram2N) ? (raw_addr - Vram2N) : raw_addr;

    s5_d.func       = s4_q.func;
    s5_d.pal_waddr  = s4_q.mem_addr[tbpf_pkg::PAL_AW-1:0];
    s5_d.write_data = s4_q.write_data;
    s5_d.hit        = s4_q.hit;
    s5_d.pal_bank   = map_entry_i[15:12];
    s5_d.byte_sel   = bpp8 ? tx[0] : tx[1];
    s5_d.nib_sel    = tx[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv_i) begin
      s4_valid_q <= s3_valid_i;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_q      <= s3_i;
      s5_q      <= s5_d;
      s5_addr_q <= addr_step;
    end
  end

  assign addr_red    = (s5_addr_q >= VramN) ? (s5_addr_q - VramN) : s5_addr_q;
  assign vram_addr_o = addr_red[AW-1:0];
  assign s5_valid_o  = s5_valid_q;
  assign s5_o        = s5_q;

endmodule

FILE: rtl/tbpf_vram.sv
// Video RAM: one write port and two registered read ports (map entry and pixel data).
// Depends on nothing outside this file.
module tbpf_vram #(
  parameter int VRAM_WORDS = 32768
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [$clog2(VRAM_WORDS)-1:0] map_addr_i,
  input  logic [$clog2(VRAM_WORDS)-1:0] tile_addr_i,
  input  logic                          wr_en_i,
  input  logic [15:0]                   wr_data_i,
  output logic [15:0]                   map_data_o,
  output logic [15:0]                   tile_data_o
);

  logic [15:0] mem_q [VRAM_WORDS];
  logic [15:0] map_q;
  logic [15:0] tile_q;

  // Writes share the pixel data address; the pixel data read in a write cycle is of the
  // same word and belongs to the write itself, so read-first behavior is all that is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[tile_addr_i] <= wr_data_i;
    end
    if (adv_i) begin
      map_q  <= mem_q[map_addr_i];
      tile_q <= mem_q[tile_addr_i];
    end
  end

  assign map_data_o  = map_q;
  assign tile_data_o = tile_q;

endmodule

FILE: rtl/tbpf_palette.sv
// Color index extraction and palette lookup stages, with the background palette RAM.
// Depends on tbpf_pkg.
module tbpf_palette (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            s5_valid_i,
  input  tbpf_pkg::tile_t s5_i,
  input  logic [15:0]     tile_data_i,
  input  tbpf_pkg::cfg_t  cfg_i,
  output logic            s7_valid_o,
  output tbpf_pkg::out_t  s7_data_o
);

  logic                        s6_valid_q;
  tbpf_pkg::tile_t             s6_q;
  logic                        s7_valid_q;
  logic                        s7_opaque_q;
  logic [15:0]                 pal_mem_q [tbpf_pkg::PAL_ENTRIES];
  logic [15:0]                 pal_q;

  logic [7:0]                  pix_byte;
  logic [3:0]                  pix_nib;
  logic [tbpf_pkg::PAL_AW-1:0] pal_raddr;
  logic                        opaque_d;
  logic                        pal_we;

  always_comb begin
    pix_byte  = s6_q.byte_sel ? tile_data_i[15:8] : tile_data_i[7:0];
    pix_nib   = s6_q.nib_sel ? pix_byte[7:4] : pix_byte[3:0];
    // A 4bpp index sits in the 16-color bank that the map entry selects.
    pal_raddr = cfg_i.bg_control[7] ? pix_byte : {s6_q.pal_bank, pix_nib};
    opaque_d  = s6_q.hit && (cfg_i.bg_control[7] ? (pix_byte != 8'd0) : (pix_nib != 4'd0));
    pal_we    = adv_i && s6_valid_q && (s6_q.func == tbpf_pkg::FUNC_PAL_WR);
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem_q[s6_q.pal_waddr] <= s6_q.write_data;
    end
    if (adv_i) begin
      pal_q       <= pal_mem_q[pal_raddr];
      s6_q        <= s5_i;
      s7_opaque_q <= opaque_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else if (adv_i) begin
      s6_valid_q <= s5_valid_i;
      s7_valid_q <= s6_valid_q;
    end
  end

  assign s7_valid_o       = s7_valid_q;
  assign s7_data_o.color  = s7_opaque_q ? pal_q[14:0] : 15'd0;
  assign s7_data_o.opaque = s7_opaque_q;

endmodule

FILE: rtl/tbpf_out_buf.sv
// Two-word output buffer: an output register plus a skid register.
// Depends on tbpf_pkg.
module tbpf_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbpf_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tbpf_pkg::out_t out_data_o
);

  logic           out_valid_q;
  logic           out_valid_d;
  tbpf_pkg::out_t out_q;
  tbpf_pkg::out_t out_d;
  logic           skid_valid_q;
  logic           skid_valid_d;
  tbpf_pkg::out_t skid_q;
  tbpf_pkg::out_t skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      // Output slot frees up: the skid word goes first, else the new word.
      out_valid_d  = skid_valid_q || push_i;
      out_d        = skid_valid_q ? skid_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/tiled_background_pixel_fetch.sv
// Top level of the tiled background pixel fetch block.
// Depends on tbpf_pkg, tbpf_front, tbpf_tile_addr, tbpf_vram, tbpf_palette, tbpf_out_buf.
//
// This block renders one pixel of a text-mode tiled background per input word and also
// takes video RAM and palette writes through the same channel; every input word yields
// exactly one output word, in order (writes and misses answer with color 0, opaque 0).
// It is a seven-stage pipeline that takes one word per clock unless stalled: two stages
// snap the line to the vertical mosaic grid with a restoring divider and add the scroll
// offsets, the third forms the map entry address, the map entry comes back from the
// video RAM into the fourth, the tile data address is formed and wrapped over the
// fourth and fifth, the pixel data word arrives in the sixth, and the palette read
// completes in the seventh. Each result then goes through the output buffer to the output.
// The video RAM has two read ports and one write port, which is what lets a map read and
// a pixel data read run every cycle that the pipeline advances. A pixel fetch is held at
// the input while a video RAM write is still in the front stages, so that its map entry
// read sees the new data. A two-word output buffer lets the block keep accepting while a
// finished word waits on the output; when both slots are full the pipeline stalls as a
// whole and in_ready_o drops. Neither RAM is cleared at reset: its content is undefined
// until written, and no clearing pass is run.
// Configuration writes must only be issued while no word is in flight.
module tiled_background_pixel_fetch #(
  parameter int VRAM_WORDS = 32768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tbpf_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tbpf_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(VRAM_WORDS);

  tbpf_pkg::cfg_t   cfg_q;
  logic             adv;
  logic             buf_full;
  logic             in_push;
  logic             vram_wr_pend;

  logic             s3_valid;
  tbpf_pkg::front_t s3_item;
  logic [AW-1:0]    map_addr;
  logic [15:0]      map_entry;

  logic             s5_valid;
  tbpf_pkg::tile_t  s5_item;
  logic [AW-1:0]    vram_addr;
  logic [15:0]      tile_data;
  logic             vram_we;

  logic             s7_valid;
  tbpf_pkg::out_t   s7_data;

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tbpf_pkg::CFG_BG_CONTROL:    cfg_q.bg_control    <= cfg_data_i;
        tbpf_pkg::CFG_H_SCROLL:      cfg_q.h_scroll      <= cfg_data_i[8:0];
        tbpf_pkg::CFG_V_SCROLL:      cfg_q.v_scroll      <= cfg_data_i[8:0];
        tbpf_pkg::CFG_MOSAIC_HEIGHT: cfg_q.mosaic_height <= cfg_data_i[3:0];
        tbpf_pkg::CFG_LAYER_ENABLE:  cfg_q.layer_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output buffer has room.
  assign adv        = !buf_full;
  // A fetch entering now waits while a video RAM write is in the first three stages, so that
  // the write has reached the RAM before the fetch reads its map entry.
  assign in_ready_o = adv && !((in_data_i.func == tbpf_pkg::FUNC_FETCH) && vram_wr_pend);
  assign in_push    = in_valid_i && in_ready_o;
  assign vram_we    = adv && s5_valid && (s5_item.func == tbpf_pkg::FUNC_VRAM_WR);

  tbpf_front #(
    .VRAM_WORDS(VRAM_WORDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_push_i     (in_push),
    .in_data_i     (in_data_i),
    .cfg_i         (cfg_q),
    .s3_valid_o    (s3_valid),
    .s3_o          (s3_item),
    .map_addr_o    (map_addr),
    .vram_wr_pend_o(vram_wr_pend)
  );

  tbpf_tile_addr #(
    .VRAM_WORDS(VRAM_WORDS)
  ) u_tile_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s3_valid_i (s3_valid),
    .s3_i       (s3_item),
    .map_entry_i(map_entry),
    .cfg_i      (cfg_q),
    .s5_valid_o (s5_valid),
    .s5_o       (s5_item),
    .vram_addr_o(vram_addr)
  );

  tbpf_vram #(
    .VRAM_WORDS(VRAM_WORDS)
  ) u_vram (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .map_addr_i (map_addr),
    .tile_addr_i(vram_addr),
    .wr_en_i    (vram_we),
    .wr_data_i  (s5_item.write_data),
    .map_data_o (map_entry),
    .tile_data_o(tile_data)
  );

  tbpf_palette u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s5_valid_i (s5_valid),
    .s5_i       (s5_item),
    .tile_data_i(tile_data),
    .cfg_i      (cfg_q),
    .s7_valid_o (s7_valid),
    .s7_data_o  (s7_data)
  );

  tbpf_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (adv && s7_valid),
    .push_data_i(s7_data),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/tbpf_checker.sv
// Port-level checker for the tiled background pixel fetch block, bound to its top level.
// Depends on tbpf_pkg and tiled_background_pixel_fetch.
module tbpf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input tbpf_pkg::out_t                  out_data_o
);

  // Seven pipeline stages plus two output buffer slots.
  localparam logic [3:0] MaxInFlight = 4'd9;

  logic [3:0] cnt_q;
  logic [3:0] cnt_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cnt_d   = cnt_q + {3'b0, in_acc} - {3'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 4'd0)
    else $error("output word without an accepted input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxInFlight)
    else $error("more words in flight than the pipeline holds");

  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.opaque |-> out_data_o.color == 15'd0)
    else $error("transparent word carries a nonzero color");

endmodule

bind tiled_background_pixel_fetch tbpf_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/tbpf_result_check.sv
// Result checker for the tiled background pixel fetch block.
// Depends on tbpf_pkg; it watches the item, result and register ports and predicts each word.
module tbpf_result_check #(
  parameter int VRAM_WORDS = 32768
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  tbpf_pkg::in_t                   in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  tbpf_pkg::out_t                  out_data_i,
  input  logic                            cfg_we_i,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              in_flight_o,
  output int                              mismatches_o,
  output int                              opaque_o
);
  import tbpf_pkg::*;

  logic [15:0] vram_shadow [VRAM_WORDS];
  logic [15:0] palette_shadow [PAL_ENTRIES];
  cfg_t        regs = '0;
  out_t        pixel_expect_q [$];
  int          results_seen = 0;
  int          bad_words = 0;
  int          opaque_seen = 0;

  // Color and coverage of one item, from the shadow RAMs and the current registers.
  function automatic out_t shade_pixel(input in_t w);
    out_t        r;
    int unsigned ln, blk, px, py, col, row, slot, tx, ty, byte_addr, idx, bank;
    logic [15:0] entry, half;
    r = '0;
    if (w.func != FUNC_FETCH || !regs.layer_enable || regs.bg_control[1:0] != w.pass_priority)
      return r;
    ln = w.line_y;
    if (regs.bg_control[6]) begin
      blk = regs.mosaic_height + 1;
      ln = (ln / blk) * blk;
    end
    px = w.pixel_x + regs.h_scroll;
    py = ln + regs.v_scroll;
    col = (px >> 3) & 63;
    row = (py >> 3) & 63;
    slot = (col & 31) + (row & 31) * 32;
    if (regs.bg_control[14] && (col & 32) != 0) slot += 'h400;
    if (regs.bg_control[15] && (row & 32) != 0) slot += regs.bg_control[14] ? 'h800 : 'h400;
    entry = vram_shadow[(regs.bg_control[12:8] * 'h400 + slot) % VRAM_WORDS];
    tx = px & 7;
    ty = py & 7;
    if (entry[10]) tx = 7 - tx;
    if (entry[11]) ty = 7 - ty;
    if (regs.bg_control[7]) begin
      byte_addr = regs.bg_control[3:2] * 'h4000 + entry[9:0] * 64 + ty * 8 + tx;
      bank = 0;
    end else begin
      byte_addr = regs.bg_control[3:2] * 'h4000 + entry[9:0] * 32 + ty * 4 + (tx >> 1);
      bank = entry[15:12] * 16;
    end
    half = vram_shadow[(byte_addr >> 1) % VRAM_WORDS];
    idx = byte_addr[0] ? half[15:8] : half[7:0];
    if (!regs.bg_control[7]) idx = tx[0] ? idx >> 4 : idx & 15;
    if (idx != 0) begin
      r.color = palette_shadow[(bank + idx) % PAL_ENTRIES][14:0];
      r.opaque = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      // Results are matched before new items are queued, so a word that shows up with
      // nothing outstanding is caught even if an item is accepted in the same cycle.
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (pixel_expect_q.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected result word %0d: color %h opaque %b",
                     results_seen, out_data_i.color, out_data_i.opaque);
        end else begin
          want = pixel_expect_q.pop_front();
          if (out_data_i.color !== want.color || out_data_i.opaque !== want.opaque) begin
            bad_words++;
            if (bad_words <= 10)
              $display("result word %0d: expected color %h opaque %b, got color %h opaque %b",
                       results_seen, want.color, want.opaque,
                       out_data_i.color, out_data_i.opaque);
          end
          if (want.opaque) opaque_seen++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        pixel_expect_q.push_back(shade_pixel(in_data_i));
        case (in_data_i.func)
          FUNC_VRAM_WR: vram_shadow[in_data_i.mem_addr % VRAM_WORDS] = in_data_i.write_data;
          FUNC_PAL_WR: palette_shadow[in_data_i.mem_addr % PAL_ENTRIES] = in_data_i.write_data;
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BG_CONTROL: regs.bg_control = cfg_data_i;
          CFG_H_SCROLL: regs.h_scroll = cfg_data_i[8:0];
          CFG_V_SCROLL: regs.v_scroll = cfg_data_i[8:0];
          CFG_MOSAIC_HEIGHT: regs.mosaic_height = cfg_data_i[3:0];
          CFG_LAYER_ENABLE: regs.layer_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      in_flight_o  <= pixel_expect_q.size();
      mismatches_o <= bad_words;
      opaque_o     <= opaque_seen;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the tiled background pixel fetch testbench: clock, reset, stimulus and verdict.
// Depends on tbpf_pkg, tiled_background_pixel_fetch and tbpf_result_check.
module testbench;
  import tbpf_pkg::*;

  localparam int VRAM_WORDS   = 32768;
  localparam int RANDOM_WORDS = 1600;
  localparam int PHASES       = 10;
  // Longest stretch without any accepted word before the run is declared hung. A correct
  // run never comes near it: the worst case is a register update (drain, pause, five
  // writes) plus a few back-to-back stall bursts.
  localparam int QUIET_LIMIT  = 2000;
  // Pause after the last result is out, before register writes or the end of the run.
  localparam int DRAIN_CYCLES = 20;
  // The operation code that the block must answer without storing anything.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   words_in_flight;
  int   mismatches;
  int   opaque_words;
  cfg_t cur = '0;
  int   idle_pct = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   words_sent = 0;
  int   fetches_sent = 0;
  int   settings_used = 0;

  // Stimulus-side copy of video RAM, used to write the words that a fetch reads before the fetch.
  logic [15:0] vram_copy [VRAM_WORDS];
  bit          vram_known [VRAM_WORDS];

  always #6 clk = ~clk;

  tiled_background_pixel_fetch #(
    .VRAM_WORDS(VRAM_WORDS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  tbpf_result_check #(
    .VRAM_WORDS(VRAM_WORDS)
  ) result_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_flight_o (words_in_flight),
    .mismatches_o(mismatches),
    .opaque_o    (opaque_words)
  );

  // The result side stalls in bursts. A burst starts with the
  // probability that the current phase sets; a rate of zero keeps ready high throughout.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no word accepted for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_t make_word(input logic [1:0] func, input logic [14:0] addr,
                                    input logic [15:0] data, input logic [7:0] x,
                                    input logic [7:0] y, input logic [1:0] prio);
    in_t w;
    w.func = func;
    w.mem_addr = addr;
    w.write_data = data;
    w.pixel_x = x;
    w.line_y = y;
    w.pass_priority = prio;
    return w;
  endfunction

  // VRAM word holding the map entry that the pixel at (x, y) reads under the current
  // registers. Used to steer writes right in front of the fetch that depends on them,
  // which exercises the write-to-fetch hold at the input of the block.
  function automatic logic [14:0] covering_map_word(input logic [7:0] x, input logic [7:0] y);
    int unsigned ln, px, py, col, row, slot;
    ln = y;
    if (cur.bg_control[6]) ln = ln / (cur.mosaic_height + 1) * (cur.mosaic_height + 1);
    px = x + cur.h_scroll;
    py = ln + cur.v_scroll;
    col = (px >> 3) & 63;
    row = (py >> 3) & 63;
    slot = (col & 31) + (row & 31) * 32;
    if (cur.bg_control[14] && (col & 32) != 0) slot += 'h400;
    if (cur.bg_control[15] && (row & 32) != 0) slot += cur.bg_control[14] ? 'h800 : 'h400;
    return 15'(cur.bg_control[12:8] * 'h400 + slot);
  endfunction

  // VRAM word holding the pixel data that the pixel at (x, y) reads through a given map
  // entry under the current registers.
  function automatic logic [14:0] tile_data_word(input logic [15:0] entry,
                                                 input logic [7:0] x, input logic [7:0] y);
    int unsigned ln, px, py, tx, ty, byte_addr;
    ln = y;
    if (cur.bg_control[6]) ln = ln / (cur.mosaic_height + 1) * (cur.mosaic_height + 1);
    px = x + cur.h_scroll;
    py = ln + cur.v_scroll;
    tx = px & 7;
    ty = py & 7;
    if (entry[10]) tx = 7 - tx;
    if (entry[11]) ty = 7 - ty;
    if (cur.bg_control[7])
      byte_addr = cur.bg_control[3:2] * 'h4000 + entry[9:0] * 64 + ty * 8 + tx;
    else
      byte_addr = cur.bg_control[3:2] * 'h4000 + entry[9:0] * 32 + ty * 4 + (tx >> 1);
    return 15'(byte_addr >> 1);
  endfunction

  // Presents one word and returns at the clock edge that accepts it. Valid is left high
  // so that the next word can follow without a bubble; a random gap lowers it first.
  task automatic send_word(input in_t w);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.func == FUNC_FETCH) fetches_sent++;
    if (w.func == FUNC_VRAM_WR) begin
      vram_copy[w.mem_addr % VRAM_WORDS] = w.write_data;
      vram_known[w.mem_addr % VRAM_WORDS] = 1'b1;
    end
  endtask

  // Writes a VRAM word that has not been written yet. About one word in eight is zero
  // so that fully transparent tile rows turn up.
  task automatic fill_word(input logic [14:0] addr);
    if (!vram_known[addr])
      send_word(make_word(FUNC_VRAM_WR, addr,
                          ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom),
                          8'($urandom), 8'($urandom), 2'($urandom)));
  endtask

  // Sends a fetch after writing whichever VRAM words it reads that still hold no data,
  // since neither RAM is cleared at reset.
  task automatic send_fetch(input in_t w);
    logic [14:0] map_word;
    map_word = covering_map_word(w.pixel_x, w.line_y);
    fill_word(map_word);
    fill_word(tile_data_word(vram_copy[map_word], w.pixel_x, w.line_y));
    send_word(w);
  endtask

  // Rewrites the map entry of the fetched pixel in the word right in front of the fetch.
  task automatic send_map_and_fetch(input logic [15:0] entry, input in_t w);
    fill_word(tile_data_word(entry, w.pixel_x, w.line_y));
    send_word(make_word(FUNC_VRAM_WR, covering_map_word(w.pixel_x, w.line_y), entry,
                        8'($urandom), 8'($urandom), 2'($urandom)));
    send_word(w);
  endtask

  // Registers may only change while nothing is in flight, so the pipeline is drained
  // and given a pause of a few latencies first. Upper bits of the narrow registers
  // carry random junk, which the block must ignore.
  task automatic apply_settings(input cfg_t s);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BG_CONTROL;
    cfg_data <= s.bg_control;
    @(posedge clk);
    cfg_index <= CFG_H_SCROLL;
    cfg_data <= {7'($urandom), s.h_scroll};
    @(posedge clk);
    cfg_index <= CFG_V_SCROLL;
    cfg_data <= {7'($urandom), s.v_scroll};
    @(posedge clk);
    cfg_index <= CFG_MOSAIC_HEIGHT;
    cfg_data <= {12'($urandom), s.mosaic_height};
    @(posedge clk);
    cfg_index <= CFG_LAYER_ENABLE;
    cfg_data <= {15'($urandom), s.layer_enable};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur = s;
    settings_used++;
  endtask

  initial begin
    cfg_t        s;
    logic [7:0]  x, y;
    logic [1:0]  prio, f;
    logic [14:0] addr;
    int          phase_start, roll;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every palette entry before any fetch, since neither RAM is cleared at reset
    // and a read of an unwritten entry has no defined answer. VRAM words are written on
    // demand, in front of the first fetch that reads them.
    idle_pct = 10;
    for (int i = 0; i < PAL_ENTRIES; i++)
      send_word(make_word(FUNC_PAL_WR, 15'(i), 16'($urandom), 8'($urandom), 8'($urandom),
                          2'($urandom)));

    // Directed part. Priority 2, tile base 1, map base 4, 32x32 map, 4bpp, no mosaic.
    idle_pct = 0;
    s = {16'h0406, 9'd0, 9'd0, 4'd0, 1'b1};
    apply_settings(s);
    // Address and data extremes; a palette write at index 0x7fff lands on entry 255,
    // whose bit 15 must not reach the color, and one at 0x100 wraps onto entry 0.
    send_word(make_word(FUNC_VRAM_WR, 15'h0000, 16'h0000, 8'h00, 8'h00, 2'd0));
    send_word(make_word(FUNC_VRAM_WR, 15'h7fff, 16'hffff, 8'hff, 8'hff, 2'd3));
    send_word(make_word(FUNC_PAL_WR, 15'h7fff, 16'hffff, 8'h00, 8'h00, 2'd0));
    send_word(make_word(FUNC_PAL_WR, 15'h0100, 16'h1234, 8'h00, 8'h00, 2'd0));
    // The spare operation code stores nothing and answers transparent.
    send_word(make_word(FUNC_UNUSED, 15'h7fff, 16'hffff, 8'hff, 8'hff, 2'd3));
    // Pixel (0, 0) points at tile 5, whose first data word is cleared: index zero.
    send_word(make_word(FUNC_VRAM_WR, covering_map_word(8'd0, 8'd0), 16'h0005, 8'd0, 8'd0,
                        2'd0));
    send_word(make_word(FUNC_VRAM_WR, 15'h2050, 16'h0000, 8'd0, 8'd0, 2'd0));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 2'd2));
    // Same pixel drawn at the wrong priority.
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 2'd1));
    // Map entries rewritten right before the fetch that reads them: both flips, then a
    // horizontal flip with the top palette bank.
    send_map_and_fetch(16'h0c00 | 16'($urandom_range(0, 1023)),
                       make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd17, 8'd40, 2'd2));
    send_map_and_fetch(16'hf400 | 16'($urandom_range(0, 1023)),
                       make_word(FUNC_FETCH, 15'h7fff, 16'hffff, 8'd255, 8'd255, 2'd2));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd0, 2'd2));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd255, 2'd2));

    // Layer switched off: transparent even where the priority matches.
    s.layer_enable = 1'b0;
    apply_settings(s);
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd17, 8'd40, 2'd2));

    // Every register at its maximum: 64x64 map at the last map base, so the map reads
    // wrap at the end of VRAM, 8bpp, mosaic of sixteen lines and both scrolls at 511.
    // Pixels 0 and 1 of a line read different pixel data, as horizontal mosaic does not apply.
    s = {16'hffff, 9'd511, 9'd511, 4'd15, 1'b1};
    apply_settings(s);
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 2'd3));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd1, 8'd0, 2'd3));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd255, 2'd3));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd128, 8'd17, 2'd0));
    send_map_and_fetch(16'($urandom),
                       make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd200, 8'd100, 2'd3));

    // A 64x32 map with scrolls that push the columns across the 512-pixel wrap.
    s = {16'h4042, 9'd300, 9'd200, 4'd3, 1'b1};
    apply_settings(s);
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd255, 2'd2));
    send_fetch(make_word(FUNC_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd100, 2'd2));

    // Random part: a new register setting per phase, mostly fetches at the drawn
    // priority, with VRAM writes that favor the active map and pairs in which a map
    // entry is rewritten just in front of the fetch that reads it. The last phase
    // runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      s.bg_control = 16'($urandom);
      s.h_scroll = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                               : 9'($urandom);
      s.v_scroll = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                               : 9'($urandom);
      s.mosaic_height = 4'($urandom);
      s.layer_enable = ($urandom_range(0, 6) != 0);
      apply_settings(s);
      if (p == PHASES - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 8;
          default: idle_pct = 25;
        endcase
      end
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
        x = 8'($urandom);
        y = 8'($urandom);
        prio = ($urandom_range(0, 4) != 0) ? cur.bg_control[1:0] : 2'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          send_map_and_fetch(16'($urandom),
                             make_word(FUNC_FETCH, 15'($urandom), 16'($urandom), x, y, prio));
        end else begin
          addr = 15'($urandom);
          if (roll < 23) begin
            f = FUNC_VRAM_WR;
            if ($urandom_range(0, 1))
              addr = 15'(cur.bg_control[12:8] * 'h400 + $urandom_range(0, 'hfff));
          end else if (roll < 30) begin
            f = FUNC_PAL_WR;
          end else if (roll < 32) begin
            f = FUNC_UNUSED;
          end else begin
            f = FUNC_FETCH;
          end
          if (f == FUNC_FETCH)
            send_fetch(make_word(f, addr, 16'($urandom), x, y, prio));
          else
            send_word(make_word(f, addr, 16'($urandom), x, y, prio));
        end
      end
    end

    // Wait for every outstanding result, then a while longer to catch stray words.
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d words, %0d of them pixel fetches, %0d drawn opaque,",
             words_sent, fetches_sent, opaque_words);
    $display("over %0d register settings after loading the whole palette.",
             settings_used);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d result words were wrong", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tbpf_pkg.sv
rtl/tbpf_front.sv
rtl/tbpf_tile_addr.sv
rtl/tbpf_vram.sv
rtl/tbpf_palette.sv
rtl/tbpf_out_buf.sv
rtl/tiled_background_pixel_fetch.sv
rtl/tbpf_checker.sv
tb/sv/tbpf_result_check.sv
tb/sv/testbench.sv
